// ----- sv/fir_pkg.sv -----
// ----------------------------------------------------------------------------
// FIR filter package
// Shared widths, operation codes and the cell control bundle of the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int SUM_W    = 36;
	localparam int TAP_W    = 5;
	localparam int INDEX_W  = 4;

	localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_COEF  = 2'd2
	} op_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic coef_we;
		logic enable;
	} cell_ctl_t;

endpackage

// ----- sv/fir_cell.sv -----
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one history sample and one coefficient, and adds its product to the
// partial sum that travels along the row of cells.
// ----------------------------------------------------------------------------
module fir_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fir_pkg::cell_ctl_t                 ctl,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] coef_in,
	input  logic                               tok_in,
	input  logic signed [fir_pkg::SUM_W-1:0]    sum_in,
	output logic signed [fir_pkg::SAMPLE_W-1:0] hist_out,
	output logic                               tok_out,
	output logic signed [fir_pkg::SUM_W-1:0]    sum_out
);
	import fir_pkg::*;

	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [SAMPLE_W-1:0] coef_q;
	logic signed [PROD_W-1:0]   product_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			coef_q <= '0;
			tok_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				hist_q <= '0;
			end else if (ctl.shift) begin
				hist_q <= sample_in;
			end
			if (ctl.coef_we) begin
				coef_q <= coef_in;
			end
			tok_q <= tok_in && ctl.enable;
		end
	end

	always_ff @(posedge clk) begin
		product_q <= hist_q * coef_q;
		if (tok_in && ctl.enable) begin
			sum_q <= sum_in + SUM_W'(product_q);
		end
	end

	assign hist_out = hist_q;
	assign tok_out  = tok_q;
	assign sum_out  = sum_q;

endmodule

// ----- sv/fir_filter_mac.sv -----
// ----------------------------------------------------------------------------
// FIR filter with a row of multiply-accumulate cells
// Direct-form FIR filter on signed 16-bit samples and Q1.15 coefficients.
// ----------------------------------------------------------------------------
// A push transaction shifts the new sample into the history and returns the
// exact 36-bit sum of products, scaled by 2^15. The partial sum walks through
// one tap cell per cycle. A push with taps in use keeps the filter busy, and
// new transactions wait, until its result has gone to the output register;
// while the output is stalled it waits in a pending register. A push with no
// taps returns zero; clear and coefficient-write transactions return nothing.
// The tap count register has its own channel; write it only while the filter
// is idle, which the block does not enforce. Values above MAX_TAPS saturate.
module fir_filter_mac #(
	parameter int MAX_TAPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          operation,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] sample,
	input  logic [fir_pkg::INDEX_W-1:0]         coef_index,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] coef_value,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [fir_pkg::SUM_W-1:0]    filtered,
	input  logic                                tap_count_valid,
	output logic                                tap_count_ready,
	input  logic [fir_pkg::TAP_W-1:0]           tap_count
);
	import fir_pkg::*;

	localparam int NW = $clog2(MAX_TAPS + 1);
	localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [TAP_W-1:0]        tap_count_q;
	logic [NW-1:0]           n_taps;
	logic [IW-1:0]           last_idx;
	logic                    item_acc;
	logic                    push;
	logic                    clear;
	logic                    coef_wr;
	logic                    busy_q;
	logic                    pend_q;
	logic signed [SUM_W-1:0] pend_data_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] out_data_q;
	logic                    go_s1;
	logic                    go_s2;
	logic                    done;
	logic                    out_free;
	logic                    new_res;
	logic signed [SUM_W-1:0] new_data;

	logic signed [SAMPLE_W-1:0] hist [MAX_TAPS];
	logic signed [SUM_W-1:0]    sums [MAX_TAPS];
	logic [MAX_TAPS-1:0]        tok;
	cell_ctl_t                  ctl  [MAX_TAPS];

	always_comb begin
		if (32'(tap_count_q) > MAX_TAPS) begin
			n_taps = NW'(MAX_TAPS);
		end else begin
			n_taps = NW'(tap_count_q);
		end
	end

	assign last_idx = IW'(n_taps - NW'(1));

	assign item_stall = busy_q || pend_q;
	assign item_acc   = item_valid && !item_stall;
	assign push       = item_acc && (operation == OP_PUSH);
	assign clear      = item_acc && (operation == OP_CLEAR);
	assign coef_wr    = item_acc && (operation == OP_COEF);

	assign tap_count_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (tap_count_valid && tap_count_ready) begin
			tap_count_q <= tap_count;
		end
	end

	genvar i;
	generate
		for (i = 0; i < MAX_TAPS; i++) begin : g_cell
			logic signed [SAMPLE_W-1:0] smp_in;
			logic                       t_in;
			logic signed [SUM_W-1:0]    s_in;

			if (i == 0) begin : g_head
				assign smp_in = sample;
				assign t_in   = go_s2;
				assign s_in   = '0;
			end else begin : g_body
				assign smp_in = hist[i-1];
				assign t_in   = tok[i-1];
				assign s_in   = sums[i-1];
			end

			assign ctl[i].enable  = 32'(n_taps) > i;
			assign ctl[i].shift   = push && (32'(n_taps) > i);
			assign ctl[i].clear   = clear;
			assign ctl[i].coef_we = coef_wr && (32'(coef_index) == i);

			fir_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl[i]),
				.sample_in(smp_in),
				.coef_in  (coef_value),
				.tok_in   (t_in),
				.sum_in   (s_in),
				.hist_out (hist[i]),
				.tok_out  (tok[i]),
				.sum_out  (sums[i])
			);
		end
	endgenerate

	assign done     = busy_q && tok[last_idx];
	assign out_free = !out_valid_q || !result_stall;
	assign new_res  = done || (push && (n_taps == '0));
	assign new_data = done ? sums[last_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			go_s1       <= 1'b0;
			go_s2       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_s1 <= push && (n_taps != '0);
			go_s2 <= go_s1;
			if (push && (n_taps != '0)) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			priority if (pend_q && out_free) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (new_res && out_free) begin
				out_valid_q <= 1'b1;
			end else if (new_res) begin
				pend_q <= 1'b1;
			end else begin
				out_valid_q <= out_valid_q && !out_free;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (pend_q && out_free) begin
			out_data_q <= pend_data_q;
		end else if (new_res && out_free) begin
			out_data_q <= new_data;
		end else if (new_res) begin
			pend_data_q <= new_data;
		end else begin
			out_data_q <= out_data_q;
		end
	end

	assign result_valid = out_valid_q;
	assign filtered     = out_data_q;

endmodule
